// File: rtl/assert_macros.svh
// assertion macros for the rtl files, included by modular_exponentiation.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clk outside reset
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked on every rising clk outside reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/mexp_pkg.sv
// types and constants of the modular exponentiation block
package mexp_pkg;

    localparam int BASE_W     = 64;
    localparam int MOD_W      = 63;
    localparam int EXP_PORT_W = 64;
    localparam int CFG_DATA_W = 64;
    localparam int DIV_CNT_W  = 6;

    localparam logic [EXP_PORT_W-1:0] ExpReset = 64'd65537;
    localparam logic [MOD_W-1:0]      ModReset = 63'd3233;

    typedef enum logic [0:0] {
        CFG_EXPONENT = 1'b0,
        CFG_MODULUS  = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MULR,
        ST_MULB,
        ST_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic start_r;
        logic start_b;
        logic mul_step;
        logic store_r;
        logic store_b;
        logic e_shift;
        logic publish;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic mod_small;
        logic div_last;
        logic e_zero;
        logic e_lsb;
        logic y_zero;
        logic out_busy;
    } dp_status_t;

endpackage

// File: rtl/mexp_base_if.sv
// channel carrying the base word into the block
interface mexp_base_if;
    logic                        valid;
    logic                        ready;
    logic [mexp_pkg::BASE_W-1:0] base_value;

    modport source (output valid, output base_value, input ready);
    modport sink (input valid, input base_value, output ready);
endinterface

// File: rtl/mexp_power_if.sv
// channel carrying the result word out of the block
interface mexp_power_if;
    logic                       valid;
    logic                       ready;
    logic [mexp_pkg::MOD_W-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink (input valid, input power_result, output ready);
endinterface

// File: rtl/modular_exponentiation.sv
// operation: a taken base word is reduced mod the modulus one base bit per step, then for each
// exponent bit up to its top set bit a check state, for a set bit a product, and a squaring;
// both step once per bit of the reduced base, and a modulus below two goes straight to done
// throughput: one word at a time, the next base word is taken once the result is registered,
// while that result may still wait at the output; the shared shift-and-add unit sets the pace
// reset: rst_n clears control state and loads exponent 65537 and modulus 3233
`include "assert_macros.svh"

module modular_exponentiation
#(
    parameter int WORD_BITS = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    mexp_base_if.sink                       base_ch,
    mexp_power_if.source                    power_ch,
    input  logic                            cfg_we,
    input  mexp_pkg::cfg_idx_t              cfg_index,
    input  logic [mexp_pkg::CFG_DATA_W-1:0] cfg_data
);

    // configuration registers, only the used exponent bits are kept
    logic [WORD_BITS-1:0]         exponent_reg;
    logic [mexp_pkg::MOD_W-1:0]   modulus_reg;

    mexp_pkg::dp_cmd_t    cmd;
    mexp_pkg::dp_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= mexp_pkg::ExpReset[WORD_BITS-1:0];
            modulus_reg  <= mexp_pkg::ModReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mexp_pkg::CFG_EXPONENT:
                begin
                    exponent_reg <= cfg_data[WORD_BITS-1:0];
                end
                mexp_pkg::CFG_MODULUS:
                begin
                    modulus_reg <= cfg_data[mexp_pkg::MOD_W-1:0];
                end
                default:
                begin
                    exponent_reg <= exponent_reg;
                end
            endcase
        end
    end

    // controller: steps reduction, products and squarings of each exponent bit
    mexp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (base_ch.valid),
        .in_ready (base_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: remainder unit, shift-and-add multiplier, output word register
    mexp_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .base_value   (base_ch.base_value),
        .exponent     (exponent_reg),
        .modulus      (modulus_reg),
        .out_ready    (power_ch.ready),
        .status       (status),
        .result_valid (power_ch.valid),
        .result_data  (power_ch.power_result)
    );

    // a taken base word makes the block busy in the next cycle
    `ASSERT_NEXT(a_busy_after_accept, base_ch.valid && base_ch.ready, !base_ch.ready)

    // a shown result is a residue of the modulus, or zero for a degenerate modulus
    `ASSERT_SAME(a_result_in_range, power_ch.valid,
        (power_ch.power_result < modulus_reg) || (power_ch.power_result == '0))

    // a publish command makes the result word valid
    `ASSERT_NEXT(a_result_from_publish, cmd.publish, power_ch.valid)

endmodule

// File: rtl/mexp_ctrl.sv
// sequencing state machine of the modular exponentiation block
module mexp_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mexp_pkg::dp_status_t status,
    output mexp_pkg::dp_cmd_t    cmd
);

    mexp_pkg::state_t state_reg;
    mexp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mexp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.mod_small ? mexp_pkg::ST_DONE : mexp_pkg::ST_REDUCE;
                end
            end
            mexp_pkg::ST_REDUCE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = mexp_pkg::ST_CHECK;
                end
            end
            mexp_pkg::ST_CHECK:
            begin
                if (status.e_zero)
                begin
                    state_next = mexp_pkg::ST_DONE;
                end
                else if (status.e_lsb)
                begin
                    cmd.start_r = 1'b1;
                    state_next  = mexp_pkg::ST_MULR;
                end
                else
                begin
                    cmd.start_b = 1'b1;
                    state_next  = mexp_pkg::ST_MULB;
                end
            end
            mexp_pkg::ST_MULR:
            begin
                if (!status.y_zero)
                begin
                    cmd.mul_step = 1'b1;
                end
                else
                begin
                    // keep the product, then square the base
                    cmd.store_r = 1'b1;
                    cmd.start_b = 1'b1;
                    state_next  = mexp_pkg::ST_MULB;
                end
            end
            mexp_pkg::ST_MULB:
            begin
                if (!status.y_zero)
                begin
                    cmd.mul_step = 1'b1;
                end
                else
                begin
                    cmd.store_b = 1'b1;
                    cmd.e_shift = 1'b1;
                    state_next  = mexp_pkg::ST_CHECK;
                end
            end
            mexp_pkg::ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = mexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/mexp_dp.sv
// datapath: base reduction, shift-and-add modular products, result register
module mexp_dp
#(
    parameter int WORD_BITS = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mexp_pkg::dp_cmd_t             cmd,
    input  logic [mexp_pkg::BASE_W-1:0]   base_value,
    input  logic [WORD_BITS-1:0]          exponent,
    input  logic [mexp_pkg::MOD_W-1:0]    modulus,
    input  logic                          out_ready,
    output mexp_pkg::dp_status_t          status,
    output logic                          result_valid,
    output logic [mexp_pkg::MOD_W-1:0]    result_data
);

    localparam int MW = mexp_pkg::MOD_W;

    logic [mexp_pkg::BASE_W-1:0]    base_sh_reg;
    logic [mexp_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [MW-1:0]                  b_reg;
    logic [MW-1:0]                  r_reg;
    logic [WORD_BITS-1:0]           e_reg;
    logic [MW-1:0]                  acc_reg;
    logic [MW-1:0]                  x_reg;
    logic [MW-1:0]                  y_reg;
    logic [MW-1:0]                  result_reg;
    logic                           out_valid_reg;

    logic [MW:0]   mod_ext;
    logic [MW:0]   rem_shift;
    logic [MW:0]   rem_next;
    logic [MW:0]   acc_sum;
    logic [MW:0]   acc_next;
    logic [MW:0]   x_dbl;
    logic [MW:0]   x_next;

    assign mod_ext = {1'b0, modulus};

    // one restoring step of base mod modulus, remainder lives in b_reg
    assign rem_shift = {b_reg, base_sh_reg[mexp_pkg::BASE_W-1]};
    assign rem_next  = (rem_shift >= mod_ext) ? (rem_shift - mod_ext) : rem_shift;

    // add and double, each followed by a conditional subtract
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, x_reg};
    assign acc_next = (acc_sum >= mod_ext) ? (acc_sum - mod_ext) : acc_sum;
    assign x_dbl    = {x_reg, 1'b0};
    assign x_next   = (x_dbl >= mod_ext) ? (x_dbl - mod_ext) : x_dbl;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_sh_reg <= base_value;
            cnt_reg     <= '0;
            b_reg       <= '0;
            r_reg       <= MW'(1);
            e_reg       <= exponent;
        end
        if (cmd.div_step)
        begin
            b_reg       <= rem_next[MW-1:0];
            base_sh_reg <= {base_sh_reg[mexp_pkg::BASE_W-2:0], 1'b0};
            cnt_reg     <= cnt_reg + 1'b1;
        end
        if (cmd.start_r)
        begin
            x_reg   <= r_reg;
            y_reg   <= b_reg;
            acc_reg <= '0;
        end
        if (cmd.start_b)
        begin
            x_reg   <= b_reg;
            y_reg   <= b_reg;
            acc_reg <= '0;
        end
        if (cmd.mul_step)
        begin
            if (y_reg[0])
            begin
                acc_reg <= acc_next[MW-1:0];
            end
            x_reg <= x_next[MW-1:0];
            y_reg <= {1'b0, y_reg[MW-1:1]};
        end
        if (cmd.store_r)
        begin
            r_reg <= acc_reg;
        end
        if (cmd.store_b)
        begin
            b_reg <= acc_reg;
        end
        if (cmd.e_shift)
        begin
            e_reg <= {1'b0, e_reg[WORD_BITS-1:1]};
        end
        if (cmd.publish)
        begin
            result_reg <= status.mod_small ? '0 : r_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.mod_small = (modulus[MW-1:1] == '0);
    assign status.div_last  = (cnt_reg == '1);
    assign status.e_zero    = (e_reg == '0);
    assign status.e_lsb     = e_reg[0];
    assign status.y_zero    = (y_reg == '0);
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign result_valid = out_valid_reg;
    assign result_data  = result_reg;

endmodule

// File: dv/tb.sv
// self-checking testbench of modular_exponentiation: predicted powers against result words
`timescale 1ns / 100ps

module tb;

    // exponent bits the block walks through, lowest first
    localparam int WORD_BITS = 64;
    localparam bit [63:0] EXP_MASK = ~64'd0 >> (64 - WORD_BITS);
    // longest stretch with no word moved on either channel; it must cover a
    // full-width exponent with a 63-bit modulus for one base word
    localparam int IDLE_LIMIT = 40000;
    localparam bit [62:0] MOD_MAX = {63{1'b1}};
    localparam bit [63:0] ALL_ONES = ~64'd0;

    logic clk;
    logic rst_n;
    logic cfg_we;
    mexp_pkg::cfg_idx_t cfg_index;
    logic [mexp_pkg::CFG_DATA_W-1:0] cfg_data;

    mexp_base_if base_if ();
    mexp_power_if power_if ();

    modular_exponentiation #(
        .WORD_BITS(WORD_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .base_ch(base_if),
        .power_ch(power_if),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // shadow copy of the register file, reset values
    bit [63:0] exponent_cfg = 64'd65537;
    bit [62:0] modulus_cfg = 63'd3233;

    // powers waiting for their result word, oldest first
    bit [62:0] expected_powers[$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;

    // idling switch shared by sender and receiver, with the burst and stall counts of each
    bit idling_on = 1'b0;
    int unsigned burst_left = 0;
    int unsigned stall_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // x * y mod m by shift-and-add; x, y < m < 2^63 keeps every sum in 64 bits
    function automatic bit [63:0] mulmod_shift_add(bit [63:0] x, bit [63:0] y, bit [63:0] m);
        bit [63:0] acc;
        acc = 64'd0;
        while (y != 64'd0)
        begin
            if (y[0])
            begin
                acc = acc + x;
                if (acc >= m)
                    acc = acc - m;
            end
            x = x << 1;
            if (x >= m)
                x = x - m;
            y = y >> 1;
        end
        return acc;
    endfunction

    // base ^ exponent mod modulus under the current register settings
    function automatic bit [62:0] predict_power(bit [63:0] base_word);
        bit [63:0] m;
        bit [63:0] e;
        bit [63:0] b;
        bit [63:0] r;
        m = {1'b0, modulus_cfg};
        e = exponent_cfg & EXP_MASK;
        // a modulus of zero or one gives zero whatever the exponent
        if (m < 64'd2)
            return 63'd0;
        b = base_word % m;
        r = 64'd1;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (e == 64'd0)
                break;
            if (e[0])
                r = mulmod_shift_add(r, b, m);
            b = mulmod_shift_add(b, b, m);
            e = e >> 1;
        end
        return r[62:0];
    endfunction

    // random word of the given bit length
    function automatic bit [63:0] random_bits(int unsigned width);
        bit [63:0] w;
        w = {$urandom, $urandom};
        if (width < 64)
            w = w & ((64'd1 << width) - 64'd1);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // register write, only called while no word is in flight
    task automatic write_reg(mexp_pkg::cfg_idx_t idx, bit [63:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == mexp_pkg::CFG_EXPONENT)
            exponent_cfg = data;
        else
            modulus_cfg = data[62:0];
    endtask

    // sends one base word, called at a falling edge, returns at a falling edge
    task automatic send_base(bit [63:0] base_word);
        // with idling on, bursts of random length with random gaps between them
        if (idling_on && burst_left == 0)
        begin
            base_if.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 5);
        end
        if (burst_left != 0)
            burst_left--;
        base_if.valid = 1'b1;
        base_if.base_value = base_word;
        // word moves at the rising edge where ready is seen high
        do
            @(posedge clk);
        while (!base_if.ready);
        expected_powers.push_back(predict_power(base_word));
        @(negedge clk);
        // a following send in this step raises valid again before any edge
        base_if.valid = 1'b0;
    endtask

    // pause until every expected result word is back, block then idle
    task automatic wait_all_results();
        while (expected_powers.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // with idling on, the receiver stalls on its own pattern of random-length holds
    initial
    begin
        power_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left != 0)
            begin
                power_if.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                power_if.ready = 1'b1;
                if (idling_on && $urandom_range(0, 3) == 0)
                    stall_left = $urandom_range(1, 30);
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker and watchdog
    // ------------------------------------------------------------------

    initial
    begin
        bit [62:0] want;
        forever
        begin
            @(posedge clk);
            if (rst_n && power_if.valid && power_if.ready)
            begin
                if (expected_powers.size() == 0)
                begin
                    $error("power_result with no word expected: actual %0d",
                           power_if.power_result);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_powers.pop_front();
                    if (power_if.power_result !== want)
                    begin
                        $error("power_result mismatch: expected %0d, actual %0d",
                               want, power_if.power_result);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // any accepted word on either channel restarts the count
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((base_if.valid && base_if.ready) || (power_if.valid && power_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings: exponent 65537, modulus 3233
    task automatic test_reset_settings();
        idling_on = 1'b0;
        send_base(64'd0);
        send_base(64'd1);
        send_base(64'd3232);
        send_base(64'd3233);
        send_base(ALL_ONES);
        wait_all_results();
    endtask

    // zero exponent gives one for any base
    task automatic test_zero_exponent();
        idling_on = 1'b1;
        write_reg(mexp_pkg::CFG_EXPONENT, 64'd0);
        write_reg(mexp_pkg::CFG_MODULUS, {1'b0, MOD_MAX});
        send_base(64'd0);
        send_base(64'd5);
        send_base(ALL_ONES);
        wait_all_results();
    endtask

    // modulus of zero and one forces zero, two is the smallest real modulus
    task automatic test_tiny_modulus();
        idling_on = 1'b1;
        write_reg(mexp_pkg::CFG_MODULUS, 64'd0);
        send_base(64'd7);
        wait_all_results();
        write_reg(mexp_pkg::CFG_MODULUS, 64'd1);
        write_reg(mexp_pkg::CFG_EXPONENT, 64'd3);
        send_base(ALL_ONES);
        wait_all_results();
        write_reg(mexp_pkg::CFG_MODULUS, 64'd2);
        send_base(64'd0);
        send_base(64'd1);
        send_base(ALL_ONES);
        wait_all_results();
    endtask

    // widest modulus with full, unit and top-bit-only exponents
    task automatic test_wide_settings();
        idling_on = 1'b1;
        write_reg(mexp_pkg::CFG_MODULUS, {1'b0, MOD_MAX});
        write_reg(mexp_pkg::CFG_EXPONENT, ALL_ONES);
        send_base({1'b0, MOD_MAX} - 64'd1);
        send_base(64'h8000_0000_0000_0000);
        send_base(ALL_ONES);
        send_base(64'd2);
        wait_all_results();
        write_reg(mexp_pkg::CFG_EXPONENT, 64'd1);
        send_base({1'b0, MOD_MAX});
        send_base(ALL_ONES);
        wait_all_results();
        write_reg(mexp_pkg::CFG_EXPONENT, 64'h8000_0000_0000_0000);
        send_base(64'd3);
        wait_all_results();
    endtask

    // random settings per phase, random bases within each phase
    task automatic test_random_phases();
        bit [63:0] expo;
        bit [63:0] modl;
        bit [63:0] base_word;
        for (int phase = 0; phase < 8; phase++)
        begin
            // every third phase runs without any idling
            idling_on = (phase % 3) != 0;
            case ($urandom_range(0, 9))
                0: expo = {$urandom, $urandom};
                1: expo = 64'd0;
                2: expo = 64'd1;
                default: expo = random_bits($urandom_range(1, 20));
            endcase
            case ($urandom_range(0, 19))
                0: modl = {1'b0, MOD_MAX};
                1: modl = 64'($urandom_range(0, 1));
                2, 3: modl = 64'($urandom_range(2, 16));
                default:
                begin
                    modl = random_bits($urandom_range(2, 63));
                    if (modl < 64'd2)
                        modl = 64'd2;
                end
            endcase
            write_reg(mexp_pkg::CFG_EXPONENT, expo);
            write_reg(mexp_pkg::CFG_MODULUS, modl);
            for (int n = 0; n < 10; n++)
            begin
                case ($urandom_range(0, 9))
                    0: base_word = 64'd0;
                    1: base_word = ALL_ONES;
                    2: base_word = modl - 64'd1;
                    3: base_word = modl;
                    4: base_word = random_bits($urandom_range(1, 63));
                    default: base_word = {$urandom, $urandom};
                endcase
                send_base(base_word);
            end
            wait_all_results();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = mexp_pkg::CFG_EXPONENT;
        cfg_data = '0;
        base_if.valid = 1'b0;
        base_if.base_value = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_settings();
        test_zero_exponent();
        test_tiny_modulus();
        test_wide_settings();
        test_random_phases();

        // drain and let any stray word show up
        wait_all_results();
        repeat (50) @(negedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
